>>> hw/rtl/rcpd_pkg.sv
// Shared constants, types and character codes of the run-length pattern decoder.
package rcpd_pkg;

   // Default geometry limits
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   // Field and register widths
   localparam int BYTE_W    = 8;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 4;
   localparam int COUNT_W   = 13;
   localparam int CODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int RUN_W     = 19;
   localparam int PROD_W    = COUNT_W + CFG_W;
   // Largest remainder dividend: column below the width plus a saturated count
   localparam int DVD_W     = COUNT_W + 1;

   localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = CSR_IDX_W'(1);

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_RUN   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_END   = 2'd2;

   // Cell codes
   localparam logic [CODE_W-1:0] CELL_EMPTY     = 2'd0;
   localparam logic [CODE_W-1:0] CELL_HEAD      = 2'd1;
   localparam logic [CODE_W-1:0] CELL_TAIL      = 2'd2;
   localparam logic [CODE_W-1:0] CELL_CONDUCTOR = 2'd3;

   // Pattern characters
   localparam logic [BYTE_W-1:0] CHR_END   = 8'h21; // '!'
   localparam logic [BYTE_W-1:0] CHR_ROW   = 8'h24; // '$'
   localparam logic [BYTE_W-1:0] CHR_DOT   = 8'h2E; // '.'
   localparam logic [BYTE_W-1:0] CHR_A     = 8'h41; // 'A'
   localparam logic [BYTE_W-1:0] CHR_B     = 8'h42; // 'B'
   localparam logic [BYTE_W-1:0] CHR_C     = 8'h43; // 'C'
   localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30; // '0'
   localparam logic [BYTE_W-1:0] CHR_NINE  = 8'h39; // '9'
   localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHR_TAB   = 8'h09;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_CHECK  = 7'b0000100,
      ST_ACT    = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

endpackage

>>> hw/rtl/rle_cell_pattern_decoder_core.sv
// Top level of the run-length cell pattern decoder: sequencer, state and result register.
//
// Takes one pattern byte per transfer and gives at most one result per byte: a run
// (cell code and length), an error or the end mark. The block handles one byte at a
// time and is not ready while it works. A byte that ends a number first passes the
// count check against width times height. A byte after the end or an error gives no
// result, and bad geometry gives an error. A cell symbol with a count of zero gives
// no run, and '$' may give none. The column position, a DVD_W-bit (14-bit) dividend,
// is reduced modulo the grid width by a bit-serial remainder unit that takes one
// dividend bit per cycle, once for '$' and twice for a cell symbol. A result waits in
// the output register until it is taken; the next byte is accepted meanwhile, and
// only a further result stalls on it, for as long as the receiver holds off. The user
// must write grid_width and grid_height over the csr_ port only while the block is
// idle; the block itself does not enforce this.
module rle_cell_pattern_decoder_core
   import rcpd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   // pattern bytes
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_in_byte,
   // results
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CODE_W-1:0]    rsp_cell_code,
   output logic [RUN_W-1:0]     rsp_run_length,
   output logic [STATUS_W-1:0]  rsp_status,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     grid_width_ff, grid_width_in;
   logic [CFG_W-1:0]     grid_height_ff, grid_height_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 digits_ff, digits_in;
   logic [COL_W-1:0]     column_ff, column_in;
   logic                 any_out_ff, any_out_in;
   logic                 halted_ff, halted_in;
   logic                 phase_ff, phase_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [CODE_W-1:0]    res_code_ff, res_code_in;
   logic [RUN_W-1:0]     res_len_ff, res_len_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]    rsp_code_ff, rsp_code_in;
   logic [RUN_W-1:0]     rsp_len_ff, rsp_len_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic                 mod_start;
   logic [DVD_W-1:0]     mod_dividend;
   logic                 mod_done;
   logic [CFG_W-1:0]     mod_rem;

   logic [COUNT_W-1:0]   mul_a;
   logic [PROD_W-1:0]    mul_p;
   logic                 geom_bad;
   logic                 is_digit;
   logic                 is_space;
   logic                 is_row;
   logic                 is_cell;
   logic [CODE_W-1:0]    cell_code;
   logic [COUNT_W+3:0]   count_x10;
   logic [CFG_W-1:0]     row_base;
   logic [PROD_W:0]      row_run;
   logic                 out_free;

   // Shared remainder unit
   rcpd_mod_unit #(
      .DIVIDEND_W (DVD_W),
      .DIVISOR_W  (CFG_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (grid_width_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Classify the held byte
   always_comb begin
      is_digit  = (byte_ff >= CHR_ZERO) && (byte_ff <= CHR_NINE);
      is_space  = (byte_ff == CHR_SPACE) || (byte_ff == CHR_LF) || (byte_ff == CHR_TAB);
      is_row    = (byte_ff == CHR_ROW);
      is_cell   = 1'b1;
      cell_code = CELL_EMPTY;
      case (byte_ff)
         CHR_DOT: cell_code = CELL_EMPTY;
         CHR_A:   cell_code = CELL_HEAD;
         CHR_B:   cell_code = CELL_TAIL;
         CHR_C:   cell_code = CELL_CONDUCTOR;
         default: is_cell = 1'b0;
      endcase
   end

   // Geometry limits and count arithmetic
   assign geom_bad  = (grid_width_ff == '0) || (grid_height_ff == '0) ||
                      (32'(grid_width_ff) > 32'(MAX_WIDTH)) ||
                      (32'(grid_height_ff) > 32'(MAX_HEIGHT));
   assign count_x10 = {1'b0, count_ff, 3'b000} + {3'b000, count_ff, 1'b0} +
                      (COUNT_W+4)'(byte_ff - CHR_ZERO);

   // Shared multiplier: width times height for the count check, rows for '$'
   always_comb begin
      if (state_ff == ST_DECODE) begin
         mul_a = COUNT_W'(grid_height_ff);
      end else if (count_ff > COUNT_W'(1)) begin
         mul_a = count_ff - COUNT_W'(1);
      end else begin
         mul_a = '0;
      end
      mul_p = PROD_W'(mul_a) * PROD_W'(grid_width_ff);
   end

   // Row-end run: pad the current row, or one whole row at the very start, plus count - 1 rows
   always_comb begin
      if (mod_rem != '0) begin
         row_base = grid_width_ff - mod_rem;
      end else if (any_out_ff) begin
         row_base = '0;
      end else begin
         row_base = grid_width_ff;
      end
      row_run = (PROD_W+1)'(row_base) + (PROD_W+1)'(prod_ff);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      byte_in        = byte_ff;
      count_in       = count_ff;
      digits_in      = digits_ff;
      column_in      = column_ff;
      any_out_in     = any_out_ff;
      halted_in      = halted_ff;
      phase_in       = phase_ff;
      prod_in        = prod_ff;
      res_code_in    = res_code_ff;
      res_len_in     = res_len_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_code_in    = rsp_code_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_status_in  = rsp_status_ff;
      mod_start      = 1'b0;
      mod_dividend   = DVD_W'(column_ff);
      req_ready      = 1'b0;

      // Take register writes
      if (csr_valid) begin
         if (csr_index == CSR_GRID_WIDTH) begin
            grid_width_in = csr_wdata;
         end else if (csr_index == CSR_GRID_HEIGHT) begin
            grid_height_in = csr_wdata;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               byte_in  = req_in_byte;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            prod_in = mul_p;
            if (halted_ff) begin
               state_in = ST_IDLE;
            end else if (geom_bad) begin
               halted_in     = 1'b1;
               res_code_in   = CELL_EMPTY;
               res_len_in    = '0;
               res_status_in = STATUS_ERROR;
               state_in      = ST_EMIT;
            end else if (is_digit) begin
               digits_in = 1'b1;
               if (!digits_ff) begin
                  count_in = COUNT_W'(byte_ff - CHR_ZERO);
               end else if (count_x10 > (COUNT_W+4)'(COUNT_SAT)) begin
                  count_in = COUNT_SAT;
               end else begin
                  count_in = count_x10[COUNT_W-1:0];
               end
               state_in = ST_IDLE;
            end else if (digits_ff) begin
               digits_in = 1'b0;
               state_in  = ST_CHECK;
            end else begin
               state_in = ST_ACT;
            end
         end
         ST_CHECK: begin
            if (PROD_W'(count_ff) > prod_ff) begin
               halted_in     = 1'b1;
               res_code_in   = CELL_EMPTY;
               res_len_in    = '0;
               res_status_in = STATUS_ERROR;
               state_in      = ST_EMIT;
            end else begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            prod_in = mul_p;
            if (is_space) begin
               state_in = ST_IDLE;
            end else if (byte_ff == CHR_END) begin
               halted_in     = 1'b1;
               res_code_in   = CELL_EMPTY;
               res_len_in    = '0;
               res_status_in = STATUS_END;
               state_in      = ST_EMIT;
            end else if (!is_row && !is_cell) begin
               halted_in     = 1'b1;
               res_code_in   = CELL_EMPTY;
               res_len_in    = '0;
               res_status_in = STATUS_ERROR;
               state_in      = ST_EMIT;
            end else if (is_cell && count_ff == '0) begin
               // zero-length run: drop it, count back to one
               count_in = COUNT_W'(1);
               state_in = ST_IDLE;
            end else begin
               mod_start    = 1'b1;
               mod_dividend = DVD_W'(column_ff);
               phase_in     = 1'b0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (mod_done) begin
               if (phase_ff) begin
                  column_in  = COL_W'(mod_rem);
                  any_out_in = 1'b1;
                  state_in   = ST_EMIT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (is_row) begin
               column_in = '0;
               if (count_ff > COUNT_W'(1)) begin
                  count_in = COUNT_W'(1);
               end
               if (row_run == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  any_out_in    = 1'b1;
                  res_code_in   = CELL_EMPTY;
                  res_len_in    = row_run[RUN_W-1:0];
                  res_status_in = STATUS_RUN;
                  state_in      = ST_EMIT;
               end
            end else begin
               // advance the column by the run, modulo the width
               mod_start     = 1'b1;
               mod_dividend  = DVD_W'(mod_rem) + DVD_W'(count_ff);
               phase_in      = 1'b1;
               count_in      = COUNT_W'(1);
               res_code_in   = cell_code;
               res_len_in    = RUN_W'(count_ff);
               res_status_in = STATUS_RUN;
               state_in      = ST_DIV;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = res_code_ff;
               rsp_len_in    = res_len_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         grid_width_ff  <= CFG_W'(1);
         grid_height_ff <= CFG_W'(1);
         count_ff       <= COUNT_W'(1);
         digits_ff      <= 1'b0;
         column_ff      <= '0;
         any_out_ff     <= 1'b0;
         halted_ff      <= 1'b0;
         phase_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         count_ff       <= count_in;
         digits_ff      <= digits_in;
         column_ff      <= column_in;
         any_out_ff     <= any_out_in;
         halted_ff      <= halted_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      prod_ff       <= prod_in;
      res_code_ff   <= res_code_in;
      res_len_ff    <= res_len_in;
      res_status_ff <= res_status_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_code  = rsp_code_ff;
   assign rsp_run_length = rsp_len_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

>>> hw/rtl/rcpd_mod_unit.sv
// Bit-serial remainder unit: one restoring step per cycle.
module rcpd_mod_unit
   import rcpd_pkg::*;
#(
   parameter int DIVIDEND_W = DVD_W,
   parameter int DIVISOR_W  = CFG_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   // Shift in the next dividend bit and subtract the divisor where it fits
   always_comb begin
      trial   = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[DIVISOR_W-1:0];
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
